// ----- sv/fvn_pkg.sv -----
// shared constants, field types and codes for the fractal value noise pixel unit
package fvn_pkg;

  // lattice and arithmetic configuration
  localparam int LATTICE_SIZE = 64;
  localparam int OCTAVES      = 4;
  localparam int FRAC_BITS    = 12;

  // derived sizes
  localparam int LAT_BITS   = $clog2(LATTICE_SIZE);
  localparam int ADDR_BITS  = 2 * LAT_BITS;
  localparam int DEPTH      = LATTICE_SIZE * LATTICE_SIZE;
  localparam int OCT_W      = (OCTAVES > 1) ? $clog2(OCTAVES) : 1;
  localparam int COORD_W    = FRAC_BITS + LAT_BITS;
  localparam int PIXEL_W    = 10;
  localparam int STEP_W     = 12;
  localparam int TIME_W     = 18;
  localparam int BASE_W     = PIXEL_W + STEP_W;
  localparam int VAL_W      = 8;
  localparam int N_W        = VAL_W + FRAC_BITS;
  localparam int SUM_W      = N_W + 1;
  localparam int CNT_W      = 3;

  // register reset and colour constants
  localparam logic [STEP_W-1:0] STEP_RESET  = STEP_W'(205);
  localparam logic [VAL_W-1:0]  BLUE_OFFSET = VAL_W'(40);
  localparam logic [VAL_W-1:0]  GRAY_MAX    = VAL_W'(255);

  // smoothstep constant 3*ONE
  localparam logic [FRAC_BITS+1:0] SMOOTH_THREE = (FRAC_BITS + 2)'(3 * (1 << FRAC_BITS));

  // command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  // one corner read per cycle, then a last step that collects the final corner
  localparam logic [CNT_W-1:0] READ_LAST = CNT_W'(4);

  typedef struct packed {
    logic              command;
    logic [5:0]        lattice_col;
    logic [5:0]        lattice_row;
    logic [VAL_W-1:0]  lattice_value;
    logic [PIXEL_W-1:0] pixel_x;
    logic [PIXEL_W-1:0] pixel_y;
    logic [TIME_W-1:0] time_offset;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] gray_level;
    logic [VAL_W-1:0] blue_level;
  } out_item_t;

  // sequencer states, one-hot
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SCALE = 8'b0000_0010,
    S_COORD = 8'b0000_0100,
    S_READ  = 8'b0000_1000,
    S_ROW   = 8'b0001_0000,
    S_COL   = 8'b0010_0000,
    S_ACC   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

endpackage

// ----- sv/fvn_ram.sv -----
// generic single-port ram with registered read
module fvn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read one entry per cycle, and write it too when we is set
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- sv/fvn_smooth.sv -----
// two-stage smoothstep weight f*f*(3-2f) in fixed point
module fvn_smooth (
  input  logic                          clk,
  input  logic [fvn_pkg::FRAC_BITS-1:0] frac,
  output logic [fvn_pkg::FRAC_BITS-1:0] weight
);

  localparam int F = fvn_pkg::FRAC_BITS;

  logic [2*F-1:0] square;
  logic [F-1:0]   sq_reg;
  logic [F+1:0]   slope;
  logic [2*F+1:0] product;

  // f*f, truncated to the fraction
  assign square = frac * frac;
  // 3 - 2f, frac is held steady while the pipe runs
  assign slope   = fvn_pkg::SMOOTH_THREE - {1'b0, frac, 1'b0};
  assign product = sq_reg * slope;

  always_ff @(posedge clk) begin
    sq_reg <= square[2*F-1:F];
    weight <= product[2*F-1:F];
  end

endmodule

// ----- sv/fractal_value_noise_pixel_unit.sv -----
// top level: lattice store, octave sequencer, bilinear blend and colour output
//
// A load item writes one lattice entry. A pixel item scales the pixel first,
// then for each octave forms the coordinate, reads the four corners through
// the single lattice RAM port and collects the last one, and performs the row
// blend, column blend and accumulation; a final step forms the colour once
// the output register is free. The next item is taken as soon as the result
// sits in the output register, even while it waits to be taken. The lattice
// is not cleared at reset: every entry must be loaded before a pixel reads it.
module fractal_value_noise_pixel_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  fvn_pkg::in_item_t          in_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output fvn_pkg::out_item_t         out_item,
  input  logic                       cfg_write_en,
  input  logic [fvn_pkg::STEP_W-1:0] cfg_write_data
);

  localparam int F = fvn_pkg::FRAC_BITS;
  localparam int L = fvn_pkg::LAT_BITS;

  fvn_pkg::state_t state, state_next;

  logic [fvn_pkg::STEP_W-1:0]  coord_step;
  logic [fvn_pkg::PIXEL_W-1:0] px, py;
  logic [fvn_pkg::COORD_W-1:0] toff;
  logic [fvn_pkg::BASE_W-1:0]  bx, by;
  logic [fvn_pkg::OCT_W-1:0]   octave;
  logic [fvn_pkg::CNT_W-1:0]   cnt;
  logic [L-1:0]                cx0, cy0;
  logic [F-1:0]                fx, fy, sx, sy;
  logic [fvn_pkg::VAL_W-1:0]   corner [4];
  logic [fvn_pkg::N_W-1:0]     n0, n1, oct_val;
  logic [fvn_pkg::SUM_W-1:0]   sum;

  logic accept, last_oct;

  // ram port
  logic                          ram_we;
  logic [fvn_pkg::ADDR_BITS-1:0] ram_addr;
  logic [fvn_pkg::VAL_W-1:0]     ram_rdata;
  logic [L-1:0]                  rd_col, rd_row;

  // coordinate of the current octave
  logic [fvn_pkg::BASE_W+fvn_pkg::OCTAVES-1:0] x_shift, y_shift;
  logic [fvn_pkg::COORD_W-1:0]                 x_coord, y_coord;

  // blend arithmetic
  logic signed [fvn_pkg::VAL_W:0]       d0, d1;
  logic signed [fvn_pkg::N_W+1:0]       p0, p1, r0, r1;
  logic signed [fvn_pkg::N_W:0]         d2;
  logic signed [fvn_pkg::N_W+F+1:0]     p2, r2;
  logic [1:0]                           corner_idx;

  // colour
  logic [fvn_pkg::SUM_W+7:0] scaled;
  logic [8:0]                gray9;
  logic [fvn_pkg::VAL_W-1:0] gray;
  logic                      out_free;

  assign in_ready = (state == fvn_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;
  assign last_oct = (octave == fvn_pkg::OCT_W'(fvn_pkg::OCTAVES - 1));
  assign out_free = !out_valid || out_ready;

  // coordinate register
  always_ff @(posedge clk) begin
    if (rst) begin
      coord_step <= fvn_pkg::STEP_RESET;
    end else if (cfg_write_en) begin
      coord_step <= cfg_write_data;
    end
  end

  // octave coordinate: base scaled by 2^octave, time added to x only
  assign x_shift = {{fvn_pkg::OCTAVES{1'b0}}, bx} << octave;
  assign y_shift = {{fvn_pkg::OCTAVES{1'b0}}, by} << octave;
  assign x_coord = x_shift[fvn_pkg::COORD_W-1:0] + toff;
  assign y_coord = y_shift[fvn_pkg::COORD_W-1:0];

  // corner address: bit 0 picks the next column, bit 1 the next row
  assign rd_col = cnt[0] ? L'(cx0 + 1'b1) : cx0;
  assign rd_row = cnt[1] ? L'(cy0 + 1'b1) : cy0;

  // lattice store port shared between loads and corner reads
  always_comb begin
    ram_we   = accept && (in_item.command == fvn_pkg::CMD_LOAD);
    ram_addr = {rd_col, rd_row};
    if (state == fvn_pkg::S_IDLE) begin
      ram_addr = {in_item.lattice_col[L-1:0], in_item.lattice_row[L-1:0]};
    end
  end

  fvn_ram #(
    .WIDTH(fvn_pkg::VAL_W),
    .DEPTH(fvn_pkg::DEPTH)
  ) u_lattice (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(in_item.lattice_value),
    .rdata(ram_rdata)
  );

  // smoothstep weights follow fx and fy through the sq_reg and weight registers
  fvn_smooth u_smooth_x (.clk(clk), .frac(fx), .weight(sx));
  fvn_smooth u_smooth_y (.clk(clk), .frac(fy), .weight(sy));

  // row blend a + (b-a)*s, exact
  assign d0 = $signed({1'b0, corner[1]}) - $signed({1'b0, corner[0]});
  assign d1 = $signed({1'b0, corner[3]}) - $signed({1'b0, corner[2]});
  assign p0 = d0 * $signed({1'b0, sx});
  assign p1 = d1 * $signed({1'b0, sx});
  assign r0 = $signed({2'b00, corner[0], {F{1'b0}}}) + p0;
  assign r1 = $signed({2'b00, corner[2], {F{1'b0}}}) + p1;

  // column blend n0 + (n1-n0)*s before truncation
  assign d2 = $signed({1'b0, n1}) - $signed({1'b0, n0});
  assign p2 = d2 * $signed({1'b0, sy});
  assign r2 = $signed({2'b00, n0, {F{1'b0}}}) + p2;

  assign corner_idx = 2'(cnt - fvn_pkg::CNT_W'(1));

  // sum*255 >> (8+F), clamped
  assign scaled = {sum, 8'b0} - (fvn_pkg::SUM_W + 8)'(sum);
  assign gray9  = scaled[fvn_pkg::SUM_W+7:fvn_pkg::N_W];
  assign gray   = (gray9 > 9'(fvn_pkg::GRAY_MAX)) ? fvn_pkg::GRAY_MAX
                                                  : gray9[fvn_pkg::VAL_W-1:0];

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      fvn_pkg::S_IDLE: begin
        if (accept && (in_item.command == fvn_pkg::CMD_PIXEL)) begin
          state_next = fvn_pkg::S_SCALE;
        end
      end
      fvn_pkg::S_SCALE: state_next = fvn_pkg::S_COORD;
      fvn_pkg::S_COORD: state_next = fvn_pkg::S_READ;
      fvn_pkg::S_READ: begin
        if (cnt == fvn_pkg::READ_LAST) begin
          state_next = fvn_pkg::S_ROW;
        end
      end
      fvn_pkg::S_ROW: state_next = fvn_pkg::S_COL;
      fvn_pkg::S_COL: state_next = fvn_pkg::S_ACC;
      fvn_pkg::S_ACC: state_next = last_oct ? fvn_pkg::S_DONE : fvn_pkg::S_COORD;
      fvn_pkg::S_DONE: begin
        if (out_free) begin
          state_next = fvn_pkg::S_IDLE;
        end
      end
      default: state_next = fvn_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fvn_pkg::S_IDLE;
      out_valid <= 1'b0;
      octave    <= '0;
      cnt       <= '0;
    end else begin
      state <= state_next;
      if (state == fvn_pkg::S_SCALE) begin
        octave <= '0;
      end else if (state == fvn_pkg::S_ACC) begin
        octave <= octave + 1'b1;
      end
      if (state == fvn_pkg::S_READ) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
      if (state == fvn_pkg::S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      px   <= in_item.pixel_x;
      py   <= in_item.pixel_y;
      toff <= in_item.time_offset[fvn_pkg::COORD_W-1:0];
    end
    if (state == fvn_pkg::S_SCALE) begin
      bx  <= px * coord_step;
      by  <= py * coord_step;
      sum <= '0;
    end
    if (state == fvn_pkg::S_COORD) begin
      cx0 <= x_coord[fvn_pkg::COORD_W-1:F];
      cy0 <= y_coord[fvn_pkg::COORD_W-1:F];
      fx  <= x_coord[F-1:0];
      fy  <= y_coord[F-1:0];
    end
    // each corner arrives the cycle after its address
    if (state == fvn_pkg::S_READ && cnt != '0) begin
      corner[corner_idx] <= ram_rdata;
    end
    if (state == fvn_pkg::S_ROW) begin
      n0 <= r0[fvn_pkg::N_W-1:0];
      n1 <= r1[fvn_pkg::N_W-1:0];
    end
    if (state == fvn_pkg::S_COL) begin
      oct_val <= r2[fvn_pkg::N_W+F-1:F];
    end
    if (state == fvn_pkg::S_ACC) begin
      sum <= sum + fvn_pkg::SUM_W'(oct_val >> octave);
    end
    if (state == fvn_pkg::S_DONE && out_free) begin
      out_item.gray_level <= gray;
      out_item.blue_level <= gray + fvn_pkg::BLUE_OFFSET;
    end
  end

`ifndef NO_ASSERTIONS
  // the lattice is only written while no pixel is in progress
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == fvn_pkg::S_IDLE)
    else $error("lattice write outside idle");

  // the corner counter never runs past the last collect cycle
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    state == fvn_pkg::S_READ |-> cnt <= fvn_pkg::READ_LAST)
    else $error("corner counter out of range");

  // a pixel run only starts from an accepted pixel item
  a_scale_start: assert property (@(posedge clk) disable iff (rst)
    state == fvn_pkg::S_SCALE |->
      $past(accept && in_item.command == fvn_pkg::CMD_PIXEL))
    else $error("pixel run without pixel item");

  // finishing a pixel always leaves a result on offer
  a_done_result: assert property (@(posedge clk) disable iff (rst)
    state == fvn_pkg::S_DONE && out_free |=> out_valid)
    else $error("pixel finished without result");

  // a pixel finishes only after its last octave
  a_octave_end: assert property (@(posedge clk) disable iff (rst)
    state == fvn_pkg::S_DONE |-> $past(state == fvn_pkg::S_DONE) || $past(last_oct))
    else $error("pixel finished before the last octave");
`endif

endmodule
